@@ hw/rtl/ps2k_pkg.sv @@
// Shared constants, types and translation tables for the PS/2 set-2 key code translator.
package ps2k_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KeyW  = 7;

	localparam logic [ByteW-1:0] RELEASE_PREFIX = 8'hF0;
	localparam logic [ByteW-1:0] EXTEND_PREFIX  = 8'hE0;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [KeyW-1:0]  key_t;

	// ROM address: the extended flag selects the upper half.
	typedef struct packed {
		logic  ext;
		byte_t code;
	} rom_addr_t;

	function automatic key_t normal_lookup(input byte_t b);
		key_t k;
		k = '0;
		case (b)
			8'h01: k = 7'h43;
			8'h03: k = 7'h3f;
			8'h04: k = 7'h3d;
			8'h05: k = 7'h3b;
			8'h06: k = 7'h3c;
			8'h07: k = 7'h61;
			8'h09: k = 7'h44;
			8'h0a: k = 7'h42;
			8'h0b: k = 7'h40;
			8'h0c: k = 7'h3e;
			8'h0d: k = 7'h0f;
			8'h0e: k = 7'h29;
			8'h11: k = 7'h38;
			8'h12: k = 7'h2a;
			8'h14: k = 7'h1d;
			8'h15: k = 7'h10;
			8'h16: k = 7'h02;
			8'h1a: k = 7'h2c;
			8'h1b: k = 7'h1f;
			8'h1c: k = 7'h1e;
			8'h1d: k = 7'h11;
			8'h1e: k = 7'h03;
			8'h21: k = 7'h2e;
			8'h22: k = 7'h2d;
			8'h23: k = 7'h20;
			8'h24: k = 7'h12;
			8'h25: k = 7'h05;
			8'h26: k = 7'h04;
			8'h29: k = 7'h39;
			8'h2a: k = 7'h2f;
			8'h2b: k = 7'h21;
			8'h2c: k = 7'h14;
			8'h2d: k = 7'h13;
			8'h2e: k = 7'h06;
			8'h31: k = 7'h31;
			8'h32: k = 7'h30;
			8'h33: k = 7'h23;
			8'h34: k = 7'h22;
			8'h35: k = 7'h15;
			8'h36: k = 7'h07;
			8'h3a: k = 7'h32;
			8'h3b: k = 7'h24;
			8'h3c: k = 7'h16;
			8'h3d: k = 7'h08;
			8'h3e: k = 7'h09;
			8'h41: k = 7'h33;
			8'h42: k = 7'h25;
			8'h43: k = 7'h17;
			8'h44: k = 7'h18;
			8'h45: k = 7'h0b;
			8'h46: k = 7'h0a;
			8'h49: k = 7'h34;
			8'h4a: k = 7'h35;
			8'h4b: k = 7'h26;
			8'h4c: k = 7'h27;
			8'h4d: k = 7'h19;
			8'h4e: k = 7'h0c;
			8'h52: k = 7'h28;
			8'h54: k = 7'h1a;
			8'h55: k = 7'h0d;
			8'h58: k = 7'h3a;
			8'h59: k = 7'h36;
			8'h5a: k = 7'h1c;
			8'h5b: k = 7'h1b;
			8'h5d: k = 7'h2b;
			8'h66: k = 7'h0e;
			8'h69: k = 7'h6d;
			8'h6b: k = 7'h6a;
			8'h6c: k = 7'h67;
			8'h70: k = 7'h70;
			8'h71: k = 7'h71;
			8'h72: k = 7'h6e;
			8'h73: k = 7'h6b;
			8'h74: k = 7'h6c;
			8'h75: k = 7'h68;
			8'h76: k = 7'h01;
			8'h78: k = 7'h62;
			8'h79: k = 7'h4e;
			8'h7a: k = 7'h6f;
			8'h7b: k = 7'h4a;
			8'h7c: k = 7'h66;
			8'h7d: k = 7'h69;
			8'h7e: k = 7'h61;
			8'h83: k = 7'h41;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic key_t extended_lookup(input byte_t b);
		key_t k;
		k = '0;
		case (b)
			8'h11: k = 7'h38;
			8'h12: k = 7'h2a;
			8'h14: k = 7'h1d;
			8'h4a: k = 7'h65;
			8'h5a: k = 7'h72;
			8'h6b: k = 7'h4b;
			8'h6c: k = 7'h47;
			8'h70: k = 7'h52;
			8'h71: k = 7'h53;
			8'h72: k = 7'h50;
			8'h74: k = 7'h4d;
			8'h75: k = 7'h48;
			8'h7a: k = 7'h64;
			8'h7d: k = 7'h63;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

@@ hw/rtl/ps2k_if.sv @@
// Valid/ready channel interfaces for PS/2 bytes in and key codes out.
interface ps2k_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ps2_byte;

	modport source (output valid, output ps2_byte, input ready);
	modport sink (input valid, input ps2_byte, output ready);
endinterface

interface ps2k_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink (input valid, input key_code, output ready);
endinterface

@@ hw/rtl/ps2k_rom.sv @@
// Synchronous translation ROM holding the normal and extended key tables.
module ps2k_rom (
	input  logic              clk,
	input  logic              rd_en,
	input  ps2k_pkg::rom_addr_t rd_addr,
	output ps2k_pkg::key_t    rd_data
);
	import ps2k_pkg::*;

	key_t data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (rd_addr.ext) begin
				data_q <= extended_lookup(rd_addr.code);
			end else begin
				data_q <= normal_lookup(rd_addr.code);
			end
		end
	end

	assign rd_data = data_q;

endmodule

@@ hw/rtl/ps2_set2_to_ikbd_scancode.sv @@
// Top level of the PS/2 set-2 to key code translator.
// From transfer to result, a PS/2 byte first reads the translation ROM at the
// byte and the extended flag, then has the release flag applied and loads the
// output register. A new byte is taken in every
// cycle; the only limit on rate is the output port, since the single ROM read
// port serves one byte per cycle. Prefix bytes and bytes that map to zero give
// no result.
module ps2_set2_to_ikbd_scancode (
	input  logic clk,
	input  logic arst_n,
	ps2k_byte_if.sink  ps2,
	ps2k_key_if.source key
);
	import ps2k_pkg::*;

	logic      accept;
	logic      advance;
	logic      ext_q;
	logic      rel_q;
	logic      valid_s1;
	logic      is_rel_s1;
	logic      is_ext_s1;
	logic      emit;
	logic      out_valid_q;
	byte_t     out_code_q;
	key_t      rom_data;
	rom_addr_t rom_addr;

	// Stage one may move on when the output register is empty or being emptied.
	assign advance = !out_valid_q || key.ready;
	assign ps2.ready = !valid_s1 || advance;
	assign accept = ps2.valid && ps2.ready;

	assign rom_addr.ext  = ext_q;
	assign rom_addr.code = ps2.ps2_byte;

	ps2k_rom u_rom (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rom_addr),
		.rd_data (rom_data)
	);

	// The extended flag does not depend on the ROM, so it is updated on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q     <= 1'b0;
			valid_s1  <= 1'b0;
			is_rel_s1 <= 1'b0;
			is_ext_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (ps2.ps2_byte == EXTEND_PREFIX) begin
					ext_q <= 1'b1;
				end else if (ps2.ps2_byte != RELEASE_PREFIX) begin
					ext_q <= 1'b0;
				end
				valid_s1  <= 1'b1;
				is_rel_s1 <= (ps2.ps2_byte == RELEASE_PREFIX);
				is_ext_s1 <= (ps2.ps2_byte == EXTEND_PREFIX);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign emit = valid_s1 && !is_rel_s1 && !is_ext_s1 && (rom_data != '0);

	// The release flag needs the ROM entry, so it is kept in step with stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s1 && advance) begin
				if (is_rel_s1) begin
					rel_q <= 1'b1;
				end else if (emit) begin
					rel_q <= 1'b0;
				end
				out_valid_q <= emit;
			end else if (key.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && emit) begin
			out_code_q <= {rel_q, rom_data};
		end
	end

	assign key.valid    = out_valid_q;
	assign key.key_code = out_code_q;

endmodule

@@ tb/sv/ps2_set2_to_ikbd_scancode_tb.sv @@
// Self-checking testbench for the PS/2 set-2 to key code translator.
module ps2_set2_to_ikbd_scancode_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ps2k_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 2000;
	localparam int unsigned RANDOM_BYTES    = 1850;
	localparam logic [7:0]  KEY_RELEASED    = 8'h80;
	localparam logic [7:0]  PAUSE_BYTE      = 8'hE1;

	// Set-2 byte to key number; bytes beyond the end map to zero.
	localparam logic [0:131][7:0] NORMAL_MAP = {
		128'h0043003f_3d3b3c61_00444240_3e0f2900,
		128'h00382a00_1d100200_00002c1f_1e110300,
		128'h002e2d20_12050400_00392f21_14130600,
		128'h00313023_22150700_00003224_16080900,
		128'h00332517_180b0a00_00343526_27190c00,
		128'h00002800_1a0d0000_3a361c1b_002b0000,
		128'h00000000_00000e00_006d006a_67000000,
		128'h70716e6b_6c680100_624e6f4a_66696100,
		32'h00000041
	};

	localparam logic [0:125][7:0] EXTENDED_MAP = {
		128'h00000000_00000000_00000000_00000000,
		128'h00382a00_1d000000_00000000_00000000,
		128'h00000000_00000000_00000000_00000000,
		128'h00000000_00000000_00000000_00000000,
		128'h00000000_00000000_00006500_00000000,
		128'h00000000_00000000_00007200_00000000,
		128'h00000000_00000000_0000004b_47000000,
		112'h52535000_4d480000_00006400_0063
	};

	class key_code_scoreboard;
		bit    release_pending;
		bit    extended_pending;
		byte_t expected_keys[$];
		int    errors;
		int    n_bytes;
		int    n_release_prefixes;
		int    n_extend_prefixes;
		int    n_keys;
		int    n_released;

		function logic [6:0] normal_key(byte_t b);
			return (b < 132) ? NORMAL_MAP[b][6:0] : 7'h00;
		endfunction

		function logic [6:0] extended_key(byte_t b);
			return (b < 126) ? EXTENDED_MAP[b][6:0] : 7'h00;
		endfunction

		// Called for every byte transfer into the translator.
		function void note_byte(byte_t b);
			logic [6:0] k;
			n_bytes++;
			if (b == RELEASE_PREFIX) begin
				release_pending = 1'b1;
				n_release_prefixes++;
			end else if (b == EXTEND_PREFIX) begin
				extended_pending = 1'b1;
				n_extend_prefixes++;
			end else begin
				if (extended_pending) begin
					k = extended_key(b);
					extended_pending = 1'b0;
				end else begin
					k = normal_key(b);
				end
				// An unmapped byte leaves the release flag standing.
				if (k != 7'h00) begin
					if (release_pending) begin
						expected_keys.push_back(KEY_RELEASED | {1'b0, k});
						release_pending = 1'b0;
					end else begin
						expected_keys.push_back({1'b0, k});
					end
				end
			end
		endfunction

		// Called for every key code transfer out of the translator.
		function void check_key(byte_t got);
			byte_t want;
			if (expected_keys.size() == 0) begin
				$display("%0t: unexpected key code, expected none, got %02h", $time, got);
				errors++;
			end else begin
				want = expected_keys.pop_front();
				n_keys++;
				if (want[7])
					n_released++;
				if (got !== want) begin
					$display("%0t: key code mismatch, expected %02h, got %02h",
						$time, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ps2k_byte_if ps2_ch ();
	ps2k_key_if  key_ch ();

	key_code_scoreboard sb;

	byte_t normal_keys[$];
	byte_t extended_keys[$];
	bit    src_calm;
	bit    sink_calm;
	int    quiet_cycles;

	ps2_set2_to_ikbd_scancode u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.ps2    (ps2_ch),
		.key    (key_ch)
	);

	always #5 clk = ~clk;

	// Each side switches now and then between running flat out and random waits.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic send_byte(input byte_t b);
		int gap;
		gap = draw_wait(src_calm);
		if (gap > 0) begin
			@(negedge clk) ps2_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		ps2_ch.valid    <= 1'b1;
		ps2_ch.ps2_byte <= b;
		do @(posedge clk); while (!ps2_ch.ready);
		sb.note_byte(b);
	endtask

	task automatic send_key(input byte_t key, input bit extended, input bit released);
		if (extended)
			send_byte(EXTEND_PREFIX);
		if (released)
			send_byte(RELEASE_PREFIX);
		send_byte(key);
	endtask

	// Key code receiver with random stalls.
	initial begin
		int stall;
		key_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(sink_calm);
			if (stall > 0) begin
				@(negedge clk) key_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) key_ch.ready <= 1'b1;
			do @(posedge clk); while (!key_ch.valid);
			sb.check_key(key_ch.key_code);
		end
	end

	always @(posedge clk) begin
		if ((ps2_ch.valid && ps2_ch.ready) || (key_ch.valid && key_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int kind;
		clk             = 1'b0;
		arst_n          = 1'b0;
		quiet_cycles    = 0;
		ps2_ch.valid    = 1'b0;
		ps2_ch.ps2_byte = '0;
		sb = new();

		for (int i = 0; i < 256; i++) begin
			if (sb.normal_key(byte_t'(i)) != 7'h00)
				normal_keys.push_back(byte_t'(i));
			if (sb.extended_key(byte_t'(i)) != 7'h00)
				extended_keys.push_back(byte_t'(i));
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: lowest and highest bytes, both prefixes, repeated prefixes,
		// an unmapped byte under a pending release, an extended byte with no
		// mapping, and the pause byte.
		send_byte(8'h00);
		send_key(8'h1C, 1'b0, 1'b0);
		send_key(8'h1C, 1'b0, 1'b1);
		send_byte(RELEASE_PREFIX);
		send_byte(8'h00);
		send_byte(8'h1C);
		send_byte(RELEASE_PREFIX);
		send_key(8'h1C, 1'b0, 1'b1);
		send_key(8'h75, 1'b1, 1'b0);
		send_key(8'h75, 1'b1, 1'b1);
		send_key(8'h1C, 1'b1, 1'b0);
		send_byte(8'h1C);
		send_byte(PAUSE_BYTE);
		send_byte(8'h83);
		send_byte(EXTEND_PREFIX);
		send_key(8'h7D, 1'b1, 1'b0);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h01);

		// Random: mostly well-formed key presses and releases, some noise.
		while (sb.n_bytes < RANDOM_BYTES + 25) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				send_key(normal_keys[$urandom_range(0, normal_keys.size() - 1)],
					1'b0, $urandom_range(0, 99) < 40);
			end else if (kind < 80) begin
				send_key(extended_keys[$urandom_range(0, extended_keys.size() - 1)],
					1'b1, $urandom_range(0, 99) < 40);
			end else if (kind < 90) begin
				send_byte(byte_t'($urandom_range(0, 255)));
			end else if (kind < 95) begin
				send_byte($urandom_range(0, 1) ? RELEASE_PREFIX : EXTEND_PREFIX);
			end else begin
				send_byte(EXTEND_PREFIX);
				send_byte(byte_t'($urandom_range(0, 255)));
			end
		end
		@(negedge clk) ps2_ch.valid <= 1'b0;

		while (sb.expected_keys.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d PS/2 bytes, %0d release and %0d extended prefixes among them.",
			sb.n_bytes, sb.n_release_prefixes, sb.n_extend_prefixes);
		$display("Checked %0d key codes, %0d of them key releases, %0d errors.",
			sb.n_keys, sb.n_released, sb.errors);
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
